// File: hdl/aabb_pkg.sv
// aabb_pkg: shared widths, motion codes and contact side type for the
// box pair collision and push-out block
// depends on nothing
package aabb_pkg;

  // field widths
  localparam int POS_W  = 20;
  localparam int SIZE_W = 16;
  localparam int MOT_W  = 4;
  localparam int TAG_W  = 2;

  // working width for doubled coordinates, sums and depths
  localparam int WRK_W = 24;

  // saturation limits of a position
  localparam logic signed [WRK_W-1:0] POS_MAX = WRK_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [WRK_W-1:0] POS_MIN = -WRK_W'(1 << (POS_W - 1));

  // packed stream widths
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 48;

  // per-axis motion sign codes (code 3 counts as zero)
  localparam logic [1:0] MOT_POS = 2'd1;
  localparam logic [1:0] MOT_NEG = 2'd2;

  // tag bits
  localparam int TAG_A_PUSHABLE = 0;
  localparam int TAG_B_PUSHES   = 1;

  typedef enum logic [2:0] {
    SIDE_SOUTH = 3'd0,
    SIDE_EAST  = 3'd1,
    SIDE_NORTH = 3'd2,
    SIDE_WEST  = 3'd3,
    SIDE_NONE  = 3'd4
  } side_t;

endpackage

// File: hdl/aabb_collide_push_out.sv
// aabb_collide_push_out: overlap test, contact side and push-out of box A
// against box B, one box pair per cycle while the output is not stalled
// depends on aabb_pkg
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata 152b box pair, in_tuser 2b tags
//  out_    | out | out_tvalid/tready  | out_tdata 48b overlap, side, new position
//
// one pair per cycle sustained while out_tready holds; a request passes through
// the input register, then the result register after the single combinational pass
// reset: rst_n synchronous active low, clears both valid flags
// a stalled result holds its register; the input register still moves into
// the result slot as soon as that slot is free, so no bubble appears
module aabb_collide_push_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height, a_motion, b_motion
  input  logic [aabb_pkg::IN_DATA_W-1:0]   in_tdata,
  // pair_tags
  input  logic [aabb_pkg::TAG_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // overlap, handled, contact_side[2:0], new_x[19:0], new_y[19:0], stop_x, stop_y,
  // one zero pad bit
  output logic [aabb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int W  = aabb_pkg::WRK_W;
  localparam int PW = aabb_pkg::POS_W;
  localparam int SW = aabb_pkg::SIZE_W;

  // doubled coordinate to position, round half up, saturated
  function automatic logic [PW-1:0] to_pos(input logic signed [W-1:0] v2);
    logic signed [W-1:0] r;
    r = (v2 + W'(1)) >>> 1;
    if (r > aabb_pkg::POS_MAX) begin
      r = aabb_pkg::POS_MAX;
    end else if (r < aabb_pkg::POS_MIN) begin
      r = aabb_pkg::POS_MIN;
    end
    return r[PW-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return (v < 0) ? W'(-v) : W'(v);
  endfunction

  // input register
  logic                                   s1_valid_r;
  logic [aabb_pkg::IN_DATA_W-1:0]         s1_data_r;
  logic [aabb_pkg::TAG_W-1:0]             s1_tags_r;

  // result register
  logic                                   out_valid_r;
  logic [aabb_pkg::OUT_DATA_W-1:0]        out_data_r;
  logic [aabb_pkg::OUT_DATA_W-1:0]        out_data_nxt;

  logic out_free;
  logic s1_move;

  // unpacked fields
  logic [PW-1:0]            a_x, a_y, b_x, b_y;
  logic [SW-1:0]            a_width, a_height, b_width, b_height;
  logic [aabb_pkg::MOT_W-1:0] a_motion, b_motion;
  logic [1:0]               avx, avy, bvx, bvy;

  // working values
  logic signed [W-1:0] ax2, ay2, bx2, by2;
  logic signed [W-1:0] aw, ah, bw, bh;
  logic signed [W-1:0] a_lo_x, a_hi_x, a_lo_y, a_hi_y;
  logic signed [W-1:0] b_lo_x, b_hi_x, b_lo_y, b_hi_y;
  logic signed [W-1:0] dx, dy, mx, my, px, py;
  logic signed [W-1:0] nx2, ny2;
  logic                ov, hd, stx, sty;
  aabb_pkg::side_t     side;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // field unpacking
  assign a_x      = s1_data_r[19:0];
  assign a_y      = s1_data_r[39:20];
  assign a_width  = s1_data_r[55:40];
  assign a_height = s1_data_r[71:56];
  assign b_x      = s1_data_r[91:72];
  assign b_y      = s1_data_r[111:92];
  assign b_width  = s1_data_r[127:112];
  assign b_height = s1_data_r[143:128];
  assign a_motion = s1_data_r[147:144];
  assign b_motion = s1_data_r[151:148];

  assign avx = a_motion[1:0];
  assign avy = a_motion[3:2];
  assign bvx = b_motion[1:0];
  assign bvy = b_motion[3:2];

  // doubled centres and full sizes (half size in doubled space)
  assign ax2 = {{(W-PW-1){a_x[PW-1]}}, a_x, 1'b0};
  assign ay2 = {{(W-PW-1){a_y[PW-1]}}, a_y, 1'b0};
  assign bx2 = {{(W-PW-1){b_x[PW-1]}}, b_x, 1'b0};
  assign by2 = {{(W-PW-1){b_y[PW-1]}}, b_y, 1'b0};
  assign aw  = {{(W-SW){1'b0}}, a_width};
  assign ah  = {{(W-SW){1'b0}}, a_height};
  assign bw  = {{(W-SW){1'b0}}, b_width};
  assign bh  = {{(W-SW){1'b0}}, b_height};

  // box edges
  assign a_lo_x = ax2 - aw;
  assign a_hi_x = ax2 + aw;
  assign a_lo_y = ay2 - ah;
  assign a_hi_y = ay2 + ah;
  assign b_lo_x = bx2 - bw;
  assign b_hi_x = bx2 + bw;
  assign b_lo_y = by2 - bh;
  assign b_hi_y = by2 + bh;

  // inclusive overlap and tag check
  assign ov = (a_hi_x >= b_lo_x) && (a_lo_x <= b_hi_x) &&
              (a_hi_y >= b_lo_y) && (a_lo_y <= b_hi_y);
  assign hd = ov && s1_tags_r[aabb_pkg::TAG_A_PUSHABLE] &&
              s1_tags_r[aabb_pkg::TAG_B_PUSHES];

  // signed penetration depths
  assign dx = ax2 - bx2;
  assign dy = ay2 - by2;
  assign mx = aw + bw;
  assign my = ah + bh;
  assign px = (dx > 0) ? (mx - dx) : (-mx - dx);
  assign py = (dy > 0) ? (my - dy) : (-my - dy);

  // contact side and push-out
  always_comb begin
    side = aabb_pkg::SIDE_NONE;
    stx  = 1'b0;
    sty  = 1'b0;
    nx2  = ax2;
    ny2  = ay2;
    if (hd && px != 0 && py != 0) begin
      if (mag(px) < mag(py)) begin
        side = (px > 0) ? aabb_pkg::SIDE_EAST : aabb_pkg::SIDE_WEST;
      end else begin
        side = (py > 0) ? aabb_pkg::SIDE_SOUTH : aabb_pkg::SIDE_NORTH;
      end
    end
    case (side)
      aabb_pkg::SIDE_SOUTH: begin
        if ((avy == aabb_pkg::MOT_NEG || bvy == aabb_pkg::MOT_POS) && a_lo_y <= b_hi_y) begin
          sty = 1'b1;
          ny2 = b_hi_y + ah;
        end
      end
      aabb_pkg::SIDE_EAST: begin
        if ((avx == aabb_pkg::MOT_NEG || bvx == aabb_pkg::MOT_POS) && a_lo_x <= b_hi_x) begin
          stx = 1'b1;
          nx2 = b_hi_x + aw;
        end
      end
      aabb_pkg::SIDE_NORTH: begin
        if ((avy == aabb_pkg::MOT_POS || bvy == aabb_pkg::MOT_NEG) && a_hi_y >= b_lo_y) begin
          sty = 1'b1;
          ny2 = b_lo_y - ah;
        end
      end
      aabb_pkg::SIDE_WEST: begin
        if ((avx == aabb_pkg::MOT_POS || bvx == aabb_pkg::MOT_NEG) && a_hi_x >= b_lo_x) begin
          stx = 1'b1;
          nx2 = b_lo_x - aw;
        end
      end
      default: begin
      end
    endcase
  end

  // result packing
  assign out_data_nxt = {1'b0, sty, stx, to_pos(ny2), to_pos(nx2), side, hd, ov};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_tags_r <= in_tuser;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_handled_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1] |-> out_data_r[0])
    else $error("handled without overlap");

  a_side_needs_handled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[4:2] != aabb_pkg::SIDE_NONE |-> out_data_r[1])
    else $error("contact side set on an unhandled pair");

  a_single_axis_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[45] && out_data_r[46]))
    else $error("both axes stopped");

  a_stop_x_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[45] |->
      (out_data_r[4:2] == aabb_pkg::SIDE_EAST || out_data_r[4:2] == aabb_pkg::SIDE_WEST))
    else $error("x stop on a vertical contact");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid flag survived reset");

endmodule
